FILE: hw/rtl/spdn_pkg.sv
package spdn_pkg;

  localparam int AuxBits = 10;

  localparam logic signed [15:0] GainA0 = 16'sd24576;
  localparam logic signed [15:0] GainA1 = 16'sd5898;
  localparam logic signed [15:0] GainA2 = -16'sd3277;
  localparam logic signed [15:0] GainA3 = 16'sd2294;
  localparam logic signed [15:0] GainB0 = 16'sd19005;
  localparam logic signed [15:0] GainB1 = -16'sd5243;
  localparam logic signed [15:0] GainB2 = 16'sd2949;
  localparam logic signed [15:0] GainB3 = 16'sd1638;
  localparam logic signed [15:0] GainPl = 16'sd8192;
  localparam logic signed [15:0] GainX1 = 16'sd2621;
  localparam logic signed [15:0] GainSl = 16'sd5898;
  localparam logic signed [15:0] GainX2 = 16'sd1966;
  localparam logic signed [15:0] GainMs = 16'sd11469;

  typedef enum logic [3:0] {
    BANK_PRE  = 4'b0001,
    BANK_DIF  = 4'b0010,
    BANK_PLP  = 4'b0100,
    BANK_SLP  = 4'b1000
  } bank_t;

  typedef struct packed {
    bank_t                      bank;
    logic                       ch;
    logic [15:0]                addr;
    logic signed [15:0]         coef;
    logic                       mac;
    logic                       last_a;
  } rd_op_t;

  function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
    if (v > 48'sd8388607) return 24'sh7fffff;
    else if (v < -48'sd8388608) return 24'sh800000;
    else return v[23:0];
  endfunction

  function automatic logic signed [47:0] rnd15(input logic signed [47:0] v);
    logic signed [47:0] t;
    t = v + 48'sd16384;
    return t >>> 15;
  endfunction

endpackage

FILE: hw/rtl/spdn_ram.sv
module spdn_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/stereo_predelay_diffuser_network_unit.sv
// Stereo predelay and diffuser network.
// Input channel in_*: tdata carries left_in, right_in, predelay_amount,
// wet_gain; tuser carries kill. Output channel out_*: tdata carries
// wet_left and wet_right. One item is processed at a time.
// After reset, and after an item with kill set, a clearing pass writes
// zero to every entry of all stores, during which in_tready stays low.
// Per channel: write and read the predelay, then twelve diffuser and loop
// taps are read one per cycle and accumulated by one multiply-add, then
// mix, gain and write-back of the stores.
// out_tvalid rises after both channels have been written back; when the
// predelay is under one sample, the taps and the mix are skipped.
// The result waits in an output register; while out_tready is low the
// block holds it and takes no new item until it is transferred.
module stereo_predelay_diffuser_network_unit
  import spdn_pkg::*;
#(
  parameter int PREDELAY_DEPTH = 32768,
  parameter int SAMPLE_RATE    = 48000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // left_in, right_in, predelay_amount, wet_gain, pad
  input  logic        in_tuser,   // kill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // wet_left, wet_right
);

  localparam int PB = (PREDELAY_DEPTH > 1) ? $clog2(PREDELAY_DEPTH) : 1;
  localparam int PW = PB + 1;
  localparam int Limit = (PREDELAY_DEPTH - 1) * 256;
  localparam logic [9:0] DA1 = 10'((SAMPLE_RATE * 67 + 50000) / 100000);
  localparam logic [9:0] DA2 = 10'((SAMPLE_RATE * 141 + 50000) / 100000);
  localparam logic [9:0] DA3 = 10'((SAMPLE_RATE * 289 + 50000) / 100000);
  localparam logic [9:0] DB1 = 10'((SAMPLE_RATE * 91 + 50000) / 100000);
  localparam logic [9:0] DB2 = 10'((SAMPLE_RATE * 187 + 50000) / 100000);
  localparam logic [9:0] DB3 = 10'((SAMPLE_RATE * 373 + 50000) / 100000);
  localparam logic [9:0] DPL = 10'((SAMPLE_RATE * 450 + 50000) / 100000);
  localparam logic [9:0] DX1L = 10'((SAMPLE_RATE * 260 + 50000) / 100000);
  localparam logic [9:0] DX1R = 10'((SAMPLE_RATE * 320 + 50000) / 100000);
  localparam logic [9:0] DL2L = 10'((SAMPLE_RATE * 530 + 50000) / 100000);
  localparam logic [9:0] DL2R = 10'((SAMPLE_RATE * 610 + 50000) / 100000);
  localparam logic [9:0] DX2L = 10'((SAMPLE_RATE * 340 + 50000) / 100000);
  localparam logic [9:0] DX2R = 10'((SAMPLE_RATE * 240 + 50000) / 100000);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_PRE   = 8'b00000100,
    S_TAPS  = 8'b00001000,
    S_MIX   = 8'b00010000,
    S_GAIN  = 8'b00100000,
    S_WB    = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [PW-1:0] clr_r;
  logic [PB-1:0] wpos_r;
  logic [AuxBits-1:0] ap_r;
  logic signed [23:0] in_l_r, in_r_r;
  logic [22:0] amt_r;
  logic [15:0] gain_r;
  logic kill_r;
  logic ch_r;
  logic [4:0] step_r;
  logic signed [23:0] a_r, b_r, p_r;
  logic signed [47:0] acc_r, mix_r;
  logic signed [23:0] prim_r, sec_r;
  logic signed [23:0] wet_l_r, wet_r_r;
  logic bypass;

  logic [PB-1:0] whole, ia, ib, ia0;
  logic [7:0] frac;
  assign whole = PB'(amt_r >> 8);
  assign frac  = amt_r[7:0];
  assign bypass = (amt_r < 23'd256);
  assign ia0 = (wpos_r >= whole) ? wpos_r - whole : wpos_r - whole + PB'(PREDELAY_DEPTH);
  assign ia  = (ia0 == '0) ? PB'(PREDELAY_DEPTH - 1) : ia0 - PB'(1);
  assign ib  = (32'(ia) == PREDELAY_DEPTH - 1) ? '0 : ia + PB'(1);

  // memory ports
  logic pre_we;
  logic [PB:0] pre_wa, pre_ra;
  logic [23:0] pre_wd, pre_rd;
  logic dif_we, plp_we, slp_we;
  logic [9:0] dif_wa, dif_ra, plp_wa, plp_ra;
  logic [10:0] slp_wa, slp_ra;
  logic [47:0] dif_wd, dif_rd;
  logic [23:0] plp_wd, plp_rd, slp_wd, slp_rd;

  spdn_ram #(.WIDTH(24), .DEPTH(2 * (1 << PB))) u_pre (
    .clk, .we(pre_we), .waddr(pre_wa), .wdata(pre_wd), .raddr(pre_ra), .rdata(pre_rd));
  spdn_ram #(.WIDTH(48), .DEPTH(1024)) u_dif (
    .clk, .we(dif_we), .waddr(dif_wa), .wdata(dif_wd), .raddr(dif_ra), .rdata(dif_rd));
  spdn_ram #(.WIDTH(24), .DEPTH(1024)) u_plp (
    .clk, .we(plp_we), .waddr(plp_wa), .wdata(plp_wd), .raddr(plp_ra), .rdata(plp_rd));
  spdn_ram #(.WIDTH(24), .DEPTH(2048)) u_slp (
    .clk, .we(slp_we), .waddr(slp_wa), .wdata(slp_wd), .raddr(slp_ra), .rdata(slp_rd));

  // tap schedule: steps 0..5 primary, 6..11 secondary
  rd_op_t op;
  always_comb begin
    op = '0;
    op.ch = ch_r;
    op.mac = 1'b1;
    unique case (step_r)
      5'd0: begin op.bank = BANK_DIF; op.addr = 16'(ap_r[8:0]);        op.coef = GainA0; end
      5'd1: begin op.bank = BANK_DIF; op.addr = 16'(9'(ap_r - DA1));   op.coef = GainA1; end
      5'd2: begin op.bank = BANK_DIF; op.addr = 16'(9'(ap_r - DA2));   op.coef = GainA2; end
      5'd3: begin op.bank = BANK_DIF; op.addr = 16'(9'(ap_r - DA3));   op.coef = GainA3; end
      5'd4: begin op.bank = BANK_PLP; op.addr = 16'(9'(ap_r - DPL));   op.coef = GainPl; end
      5'd5: begin
        op.bank = BANK_SLP; op.coef = GainX1; op.last_a = 1'b1;
        op.addr = 16'(ap_r - (ch_r ? DX1R : DX1L));
      end
      5'd6: begin op.bank = BANK_DIF; op.addr = 16'(ap_r[8:0]);        op.coef = GainB0; end
      5'd7: begin op.bank = BANK_DIF; op.addr = 16'(9'(ap_r - DB1));   op.coef = GainB1; end
      5'd8: begin op.bank = BANK_DIF; op.addr = 16'(9'(ap_r - DB2));   op.coef = GainB2; end
      5'd9: begin op.bank = BANK_DIF; op.addr = 16'(9'(ap_r - DB3));   op.coef = GainB3; end
      5'd10: begin
        op.bank = BANK_SLP; op.coef = GainSl;
        op.addr = 16'(ap_r - (ch_r ? DL2R : DL2L));
      end
      5'd11: begin
        op.bank = BANK_PLP; op.coef = GainX2;
        op.addr = 16'(9'(ap_r - (ch_r ? DX2R : DX2L)));
      end
      default: begin op.bank = BANK_PRE; op.mac = 1'b0; end
    endcase
  end

  // delayed operand of the read issued last cycle
  logic rd_v_r, rd_half_r, rd_last_r;
  bank_t rd_bank_r;
  logic signed [15:0] rd_coef_r;
  logic signed [23:0] rd_val;
  always_comb begin
    unique case (rd_bank_r)
      BANK_DIF: rd_val = rd_half_r ? dif_rd[47:24] : dif_rd[23:0];
      BANK_PLP: rd_val = plp_rd;
      BANK_SLP: rd_val = slp_rd;
      default:  rd_val = pre_rd;
    endcase
  end
  logic signed [39:0] prod;
  assign prod = rd_val * rd_coef_r;

  logic signed [23:0] interp;
  logic signed [24:0] diff;
  logic signed [34:0] dmul;
  always_comb begin
    diff = 25'(b_r) - 25'(a_r);
    dmul = diff * $signed({1'b0, 9'(10'd256 - 10'(frac))});
    interp = 24'(25'(a_r) + 25'((dmul + 35'sd128) >>> 8));
  end

  logic signed [47:0] prim_w;
  assign prim_w = bypass ? 48'(p_r) : 48'(prim_r);

  always_comb begin
    state_nxt = state_r;
    pre_we = 1'b0; pre_wa = '0; pre_wd = '0; pre_ra = '0;
    dif_we = 1'b0; dif_wa = '0; dif_wd = '0; dif_ra = '0;
    plp_we = 1'b0; plp_wa = '0; plp_wd = '0; plp_ra = '0;
    slp_we = 1'b0; slp_wa = '0; slp_wd = '0; slp_ra = '0;
    unique case (state_r)
      S_CLEAR: begin
        pre_we = 1'b1; pre_wa = clr_r[PB:0];
        dif_we = 1'b1; dif_wa = clr_r[9:0];
        plp_we = 1'b1; plp_wa = clr_r[9:0];
        slp_we = 1'b1; slp_wa = clr_r[10:0];
        if (32'(clr_r) >= 2 * (1 << PB) - 1 && 32'(clr_r) >= 2047) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_tvalid) state_nxt = S_PRE;
      S_PRE: begin
        if (step_r == 5'd0) begin
          pre_we = 1'b1; pre_wa = {ch_r, wpos_r};
          pre_wd = ch_r ? in_r_r : in_l_r;
        end
        pre_ra = {ch_r, (step_r == 5'd0) ? ((frac == 8'd0) ? ia0 : ia) : ib};
        if (step_r == 5'd3) state_nxt = bypass ? S_GAIN : S_TAPS;
      end
      S_TAPS: begin
        dif_ra = {ch_r, op.addr[8:0]};
        plp_ra = {ch_r, op.addr[8:0]};
        slp_ra = {ch_r, op.addr[9:0]};
        if (step_r == 5'd13) state_nxt = S_MIX;
      end
      S_MIX: state_nxt = S_GAIN;
      S_GAIN: state_nxt = S_WB;
      S_WB: begin
        dif_we = 1'b1; dif_wa = {ch_r, ap_r[8:0]}; dif_wd = {p_r, p_r};
        plp_we = 1'b1; plp_wa = {ch_r, ap_r[8:0]}; plp_wd = prim_w[23:0];
        slp_we = 1'b1; slp_wa = {ch_r, ap_r};
        slp_wd = bypass ? p_r : sec_r;
        state_nxt = ch_r ? S_OUT : S_PRE;
      end
      S_OUT: if (out_tready) state_nxt = kill_r ? S_CLEAR : S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      wpos_r <= '0;
      ap_r <= '0;
      step_r <= '0;
      ch_r <= 1'b0;
      rd_v_r <= 1'b0;
      rd_bank_r <= BANK_PRE;
    end else begin
      state_r <= state_nxt;
      rd_v_r <= (state_r == S_TAPS) && op.mac;
      rd_bank_r <= op.bank;
      rd_half_r <= (step_r >= 5'd6);
      rd_coef_r <= op.coef;
      rd_last_r <= op.last_a;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + PW'(1);
          wpos_r <= '0; ap_r <= '0;
        end
        S_IDLE: begin
          clr_r <= '0;
          ch_r <= 1'b0; step_r <= '0;
          {in_r_r, in_l_r} <= in_tdata[47:0];
          amt_r <= (32'(in_tdata[70:48]) > Limit) ? 23'(Limit) : in_tdata[70:48];
          gain_r <= in_tdata[86:71];
          kill_r <= in_tuser;
        end
        S_PRE: begin
          step_r <= (step_r == 5'd3) ? 5'd0 : step_r + 5'd1;
          if (step_r == 5'd1) a_r <= (amt_r == '0) ? (ch_r ? in_r_r : in_l_r) : pre_rd;
          if (step_r == 5'd2) b_r <= pre_rd;
          if (step_r == 5'd3) begin
            p_r <= (frac == 8'd0) ? a_r : interp;
            acc_r <= '0;
          end
        end
        S_TAPS: begin
          step_r <= step_r + 5'd1;
          if (rd_v_r && rd_last_r) begin
            prim_r <= sat24(rnd15(acc_r + 48'(prod)));
            acc_r <= 48'(p_r * GainB0);
          end else if (step_r == 5'd0) begin
            acc_r <= 48'(p_r * GainA0);
          end else if (rd_v_r && step_r != 5'd1 && step_r != 5'd7) begin
            acc_r <= acc_r + 48'(prod);
          end
          if (step_r == 5'd13) sec_r <= sat24(rnd15(acc_r + 48'(prod)));
        end
        S_MIX: mix_r <= 48'(prim_r) * 48'sd32768 + 48'(sec_r) * 48'(GainMs);
        S_GAIN: begin
          step_r <= '0;
          if (bypass) mix_r <= 48'(p_r) * 48'($signed({1'b0, gain_r}));
          else mix_r <= rnd15(mix_r) * 48'($signed({1'b0, gain_r}));
        end
        S_WB: begin
          if (ch_r) wet_r_r <= sat24(rnd15(mix_r));
          else wet_l_r <= sat24(rnd15(mix_r));
          ch_r <= ~ch_r;
        end
        S_OUT: if (out_tready) begin
          wpos_r <= (32'(wpos_r) == PREDELAY_DEPTH - 1) ? '0 : wpos_r + PB'(1);
          ap_r <= ap_r + AuxBits'(1);
        end
        default: ;
      endcase
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {wet_r_r, wet_l_r};

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("in and out both open");
  a_ch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ch_r) else $error("channel not reset");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
`endif

endmodule
